/* sv/cmdhdr_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package cmdhdr_pkg;

  localparam logic [2:0] CaseOne     = 3'd0;
  localparam logic [2:0] CaseTwoS    = 3'd1;
  localparam logic [2:0] CaseThreeS  = 3'd2;
  localparam logic [2:0] CaseFourS   = 3'd3;
  localparam logic [2:0] CaseTwoE    = 3'd4;
  localparam logic [2:0] CaseThreeE  = 3'd5;
  localparam logic [2:0] CaseFourE   = 3'd6;

  localparam logic [2:0] OffsNone    = 3'd0;
  localparam logic [2:0] OffsShort   = 3'd5;
  localparam logic [2:0] OffsExt     = 3'd7;

  localparam logic [16:0] LeShortZero = 17'h00100;
  localparam logic [16:0] LeExtZero   = 17'h10000;

  localparam logic [15:0] MaxLenReset = 16'd1024;
  localparam logic [15:0] CountMax    = 16'hFFFF;

  localparam logic RegMaxDataLen = 1'b0;

  typedef struct packed {
    logic [3:0][7:0] hdr;
    logic [2:0][7:0] lenb;
    logic [15:0]     count;
    logic            ovf;
    logic [7:0]      prev;
    logic [7:0]      cur;
  } snap_t;

  typedef struct packed {
    logic        malformed;
    logic [2:0]  data_offset;
    logic [2:0]  apdu_case;
    logic        extended_form;
    logic [16:0] expected_length;
    logic [15:0] command_length;
    logic [7:0]  param_two;
    logic [7:0]  param_one;
    logic [7:0]  instruction_byte;
    logic [7:0]  class_byte;
  } result_t;

endpackage

`default_nettype wire

/* sv/cmdhdr_capture.sv */
`timescale 1ns / 1ps
`default_nettype none

module cmdhdr_capture import cmdhdr_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  in_valid_i,
  output logic       in_ready_o,
  input  wire logic  [7:0] in_byte_i,
  input  wire logic  in_last_i,
  output logic       snap_valid_o,
  input  wire logic  snap_ready_i,
  output snap_t      snap_o
);

  logic [15:0]     count_q, count_d;
  logic            ovf_q, ovf_d;
  logic [3:0][7:0] hdr_q, hdr_d;
  logic [2:0][7:0] lenb_q, lenb_d;
  logic [7:0]      prev_q;
  logic            s1_v_q;
  snap_t           snap_q;
  logic            accept;

  assign in_ready_o   = !s1_v_q || snap_ready_i;
  assign accept       = in_valid_i && in_ready_o;
  assign snap_valid_o = s1_v_q;
  assign snap_o       = snap_q;

  always_comb begin
    hdr_d   = hdr_q;
    lenb_d  = lenb_q;
    count_d = count_q;
    ovf_d   = ovf_q;
    if (count_q < 16'd4) begin
      hdr_d[count_q[1:0]] = in_byte_i;
    end else if (count_q < 16'd7) begin
      lenb_d[count_q[1:0]] = in_byte_i;
    end
    if (count_q == CountMax) begin
      ovf_d = 1'b1;
    end else begin
      count_d = count_q + 16'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ovf_q   <= 1'b0;
      hdr_q   <= '0;
      lenb_q  <= '0;
      prev_q  <= '0;
      s1_v_q  <= 1'b0;
    end else begin
      if (in_ready_o) begin
        s1_v_q <= accept && in_last_i;
      end
      if (accept) begin
        if (in_last_i) begin
          count_q <= '0;
          ovf_q   <= 1'b0;
          hdr_q   <= '0;
          lenb_q  <= '0;
          prev_q  <= '0;
        end else begin
          count_q <= count_d;
          ovf_q   <= ovf_d;
          hdr_q   <= hdr_d;
          lenb_q  <= lenb_d;
          prev_q  <= in_byte_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && in_last_i) begin
      snap_q.hdr   <= hdr_d;
      snap_q.lenb  <= lenb_d;
      snap_q.count <= count_d;
      snap_q.ovf   <= ovf_d;
      snap_q.prev  <= prev_q;
      snap_q.cur   <= in_byte_i;
    end
  end

endmodule

`default_nettype wire

/* sv/cmdhdr_classify.sv */
`timescale 1ns / 1ps
`default_nettype none

module cmdhdr_classify import cmdhdr_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  [15:0] max_len_i,
  input  wire logic  snap_valid_i,
  output logic       snap_ready_o,
  input  wire snap_t snap_i,
  output logic       res_valid_o,
  input  wire logic  res_ready_i,
  output result_t    res_o
);

  logic        out_v_q;
  result_t     res_q, res_d;
  logic [16:0] len;
  logic [15:0] lc8, lc16;
  logic [16:0] sum5, sum6, sum7, sum9, le16;
  logic        bad;
  logic [15:0] lc;
  logic [16:0] le;
  logic        ext;
  logic [2:0]  kind, offs;

  assign snap_ready_o = !out_v_q || res_ready_i;
  assign res_valid_o  = out_v_q;
  assign res_o        = res_q;

  always_comb begin
    len  = {1'b0, snap_i.count};
    lc8  = {8'd0, snap_i.lenb[0]};
    lc16 = {snap_i.lenb[1], snap_i.lenb[2]};
    sum5 = {1'b0, lc8} + 17'd5;
    sum6 = {1'b0, lc8} + 17'd6;
    sum7 = {1'b0, lc16} + 17'd7;
    sum9 = {1'b0, lc16} + 17'd9;
    le16 = {1'b0, snap_i.prev, snap_i.cur};
    bad  = 1'b0;
    lc   = '0;
    le   = '0;
    ext  = 1'b0;
    kind = CaseOne;
    offs = OffsNone;
    if (snap_i.ovf || len < 17'd4) begin
      bad = 1'b1;
    end else if (len == 17'd4) begin
      kind = CaseOne;
    end else if (len == 17'd5) begin
      kind = CaseTwoS;
      le   = (lc8 != 16'd0) ? {1'b0, lc8} : LeShortZero;
    end else if (lc8 != 16'd0 && len == sum5) begin
      kind = CaseThreeS;
      lc   = lc8;
      bad  = lc8 > max_len_i;
      le   = LeShortZero;
      offs = OffsShort;
    end else if (lc8 != 16'd0 && len == sum6) begin
      kind = CaseFourS;
      lc   = lc8;
      bad  = lc8 > max_len_i;
      le   = (snap_i.cur != 8'd0) ? {9'd0, snap_i.cur} : LeShortZero;
      offs = OffsShort;
    end else if (len == 17'd7) begin
      if (lc8 != 16'd0) begin
        bad = 1'b1;
      end else begin
        kind = CaseTwoE;
        ext  = 1'b1;
        le   = (lc16 != 16'd0) ? {1'b0, lc16} : LeExtZero;
      end
    end else if (lc8 != 16'd0 || len < 17'd7) begin
      bad = 1'b1;
    end else begin
      ext  = 1'b1;
      offs = OffsExt;
      lc   = lc16;
      if (lc16 == 16'd0) begin
        bad = 1'b1;
      end else if (len == sum7) begin
        kind = CaseThreeE;
        bad  = lc16 > max_len_i;
        le   = LeExtZero;
      end else if (len == sum9) begin
        kind = CaseFourE;
        bad  = lc16 > max_len_i;
        le   = (le16 != 17'd0) ? le16 : LeExtZero;
      end else begin
        bad = 1'b1;
      end
    end
    if (bad) begin
      lc   = '0;
      le   = '0;
      ext  = 1'b0;
      kind = CaseOne;
      offs = OffsNone;
    end
    res_d.class_byte       = snap_i.hdr[0];
    res_d.instruction_byte = snap_i.hdr[1];
    res_d.param_one        = snap_i.hdr[2];
    res_d.param_two        = snap_i.hdr[3];
    res_d.command_length   = lc;
    res_d.expected_length  = le;
    res_d.extended_form    = ext;
    res_d.apdu_case        = kind;
    res_d.data_offset      = offs;
    res_d.malformed        = bad;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (snap_ready_o) begin
      out_v_q <= snap_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (snap_valid_i && snap_ready_o) begin
      res_q <= res_d;
    end
  end

endmodule

`default_nettype wire

/* sv/command_apdu_header_parser_top.sv */
// A result word passes through the capture register, then the output register.
// Throughput: one input word per cycle while s_axis_tready is high.
// The output register and the capture stage hold words while the master side stalls.
// Reset: asynchronous, active low; clears the counter, captures and valid flags,
// and sets max_data_length to 1024.
`timescale 1ns / 1ps
`default_nettype none

module command_apdu_header_parser_top import cmdhdr_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] cmd_byte
  input  wire logic        s_axis_tlast,   // last_byte
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [7:0] class_byte, [15:8] instruction_byte, [23:16] param_one, [31:24] param_two,
  // [47:32] command_length, [64:48] expected_length, [65] extended_form,
  // [68:66] apdu_case, [71:69] data_offset, [72] malformed, [79:73] zero
  output logic [79:0]      m_axis_tdata,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [15:0] max_len_q;
  logic        snap_valid, snap_ready;
  snap_t       snap;
  result_t     res;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == RegMaxDataLen) ? {16'd0, max_len_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= MaxLenReset;
    end else if (psel && penable && pwrite && pready && paddr[2] == RegMaxDataLen) begin
      max_len_q <= pwdata[15:0];
    end
  end

  cmdhdr_capture u_capture (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_byte_i    (s_axis_tdata),
    .in_last_i    (s_axis_tlast),
    .snap_valid_o (snap_valid),
    .snap_ready_i (snap_ready),
    .snap_o       (snap)
  );

  cmdhdr_classify u_classify (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .max_len_i    (max_len_q),
    .snap_valid_i (snap_valid),
    .snap_ready_o (snap_ready),
    .snap_i       (snap),
    .res_valid_o  (m_axis_tvalid),
    .res_ready_i  (m_axis_tready),
    .res_o        (res)
  );

  assign m_axis_tdata = {7'd0, res};

endmodule

`default_nettype wire
